// ===== sv/depth_pixel_backprojection_unit_defines.svh =====
// assertion macros shared by the depth pixel back-projection unit
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef DEPTH_PIXEL_BACKPROJECTION_UNIT_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTION_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define DPBU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DPBU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/dpbu_pkg.sv =====
// shared types, widths and constants of the depth pixel back-projection unit
// no dependencies
package dpbu_pkg;

	// field widths
	localparam int ROW_W      = 9;
	localparam int COL_W      = 10;
	localparam int DEPTH_W    = 16;
	localparam int COLOR_W    = 8;
	localparam int WORLD_W    = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int HALF_W     = 16;

	// image geometry and subsampling
	localparam int IMAGE_WIDTH    = 640;
	localparam int IMAGE_HEIGHT   = 480;
	localparam int SUBSAMPLE_STEP = 3;
	localparam int GEOM_W         = 13;
	localparam logic [GEOM_W-1:0] IMG_W = GEOM_W'(IMAGE_WIDTH);
	localparam logic [GEOM_W-1:0] IMG_H = GEOM_W'(IMAGE_HEIGHT);

	// grid test by reciprocal multiply, exact for values below 2**GRID_W
	localparam int GRID_W      = 10;
	localparam int GRID_SHIFT  = 20;
	localparam int GRID_PROD_W = GRID_W + GRID_SHIFT + 1;
	localparam int GRID_RECIP  = (2**GRID_SHIFT + SUBSAMPLE_STEP - 1) / SUBSAMPLE_STEP;
	localparam logic [GRID_PROD_W-1:0] GRID_RECIP_L = GRID_PROD_W'(GRID_RECIP);
	localparam logic [GRID_PROD_W-1:0] GRID_STEP_L  = GRID_PROD_W'(SUBSAMPLE_STEP);

	// camera-space arithmetic
	localparam int PROD_W     = 2 * DEPTH_W;        // |pix*16 - centre| * depth
	localparam int NUM_W      = PROD_W + 5;         // *16 plus half divisor
	localparam int DIV_BITS   = 2;                  // quotient bits per divider stage
	localparam int DIV_STAGES = (NUM_W + DIV_BITS - 1) / DIV_BITS;
	localparam int DIV_W      = DIV_STAGES * DIV_BITS;
	localparam int COORD_W    = DIV_W;              // signed camera x/y in 1/16 mm

	// saturation bounds of a world coordinate
	localparam int WORLD_MAX = 2**(WORLD_W-1) - 1;
	localparam int WORLD_MIN = -(2**(WORLD_W-1));

	localparam int QUEUE_DEPTH_DEF = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_DEPTH  = 3'd0,
		REG_MAX_DEPTH  = 3'd1,
		REG_FOCAL      = 3'd2,
		REG_CENTER     = 3'd3,
		REG_POSE_X     = 3'd4,
		REG_POSE_Y     = 3'd5,
		REG_POSE_Z     = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0][CFG_DATA_W-1:0] pose;       // [0] world x row .. [2] world z row
		logic [2*HALF_W-1:0]        center;     // cy high, cx low
		logic [2*HALF_W-1:0]        focal;      // fy high, fx low
		logic [DEPTH_W-1:0]         max_depth;
		logic [DEPTH_W-1:0]         min_depth;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		pose:      {64'h0000_4000_0000_0000, 64'h0000_0000_4000_0000,
		            64'h0000_0000_0000_4000},
		center:    32'h0EF8_13F8,
		focal:     32'h20D0_2418,
		max_depth: 16'd10000,
		min_depth: 16'd10
	};

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} rgb_t;

	// one kept pixel handed from front to back
	typedef struct packed {
		logic [NUM_W-1:0]   num_x;
		logic               neg_x;
		logic [NUM_W-1:0]   num_y;
		logic               neg_y;
		logic [DEPTH_W-1:0] depth;
		rgb_t               rgb;
	} qent_t;

	// true when x is a multiple of the subsample step
	function automatic logic on_grid(input logic [GRID_W-1:0] x);
		logic [GRID_PROD_W-1:0] prod;
		logic [GRID_W-1:0]      quo;
		logic [GRID_PROD_W-1:0] back;
		prod = GRID_PROD_W'(x) * GRID_RECIP_L;
		quo  = prod[GRID_SHIFT +: GRID_W];
		back = GRID_PROD_W'(quo) * GRID_STEP_L;
		return back[GRID_W-1:0] == x;
	endfunction

endpackage

// ===== sv/dpbu_front.sv =====
// front end: takes pixel beats, drops the ones off grid or out of range,
// forms divider numerators for kept pixels; uses dpbu_pkg
module dpbu_front
	import dpbu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [ROW_W-1:0]   pixel_row,
	input  logic [COL_W-1:0]   pixel_col,
	input  logic [DEPTH_W-1:0] depth_mm,
	input  logic [COLOR_W-1:0] in_red,
	input  logic [COLOR_W-1:0] in_green,
	input  logic [COLOR_W-1:0] in_blue,
	input  logic               q_full,
	output logic               push,
	output qent_t              push_data
);

	localparam int DX_W = DEPTH_W + 2;

	logic                     en;
	logic                     keep;
	logic signed [DX_W-1:0]   dx;
	logic signed [DX_W-1:0]   dy;
	logic signed [DX_W-1:0]   dx_abs;
	logic signed [DX_W-1:0]   dy_abs;

	logic                     v_s1;
	logic [DEPTH_W-1:0]       dxm_s1;
	logic                     dxn_s1;
	logic [DEPTH_W-1:0]       dym_s1;
	logic                     dyn_s1;
	logic [DEPTH_W-1:0]       depth_s1;
	rgb_t                     rgb_s1;

	logic                     v_s2;
	logic [PROD_W-1:0]        px_s2;
	logic                     nx_s2;
	logic [PROD_W-1:0]        py_s2;
	logic                     ny_s2;
	logic [DEPTH_W-1:0]       depth_s2;
	rgb_t                     rgb_s2;

	// hold everything while a kept pixel waits on a full queue
	assign en       = !(v_s2 && q_full);
	assign in_stall = !en;
	assign push     = v_s2 && !q_full;

	always_comb begin
		keep = ({{(GEOM_W-ROW_W){1'b0}}, pixel_row} < IMG_H)
			&& ({{(GEOM_W-COL_W){1'b0}}, pixel_col} < IMG_W)
			&& on_grid({{(GRID_W-ROW_W){1'b0}}, pixel_row})
			&& on_grid(pixel_col)
			&& (depth_mm >= cfg.min_depth)
			&& (depth_mm <= cfg.max_depth);
		dx = $signed({{(DX_W-COL_W-4){1'b0}}, pixel_col, 4'b0000})
			- $signed({2'b00, cfg.center[HALF_W-1:0]});
		dy = $signed({{(DX_W-ROW_W-4){1'b0}}, pixel_row, 4'b0000})
			- $signed({2'b00, cfg.center[2*HALF_W-1:HALF_W]});
		dx_abs = dx[DX_W-1] ? -dx : dx;
		dy_abs = dy[DX_W-1] ? -dy : dy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid && keep;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dxm_s1   <= dx_abs[DEPTH_W-1:0];
			dxn_s1   <= dx[DX_W-1];
			dym_s1   <= dy_abs[DEPTH_W-1:0];
			dyn_s1   <= dy[DX_W-1];
			depth_s1 <= depth_mm;
			rgb_s1   <= '{red: in_red, green: in_green, blue: in_blue};
			px_s2    <= PROD_W'(dxm_s1) * PROD_W'(depth_s1);
			nx_s2    <= dxn_s1;
			py_s2    <= PROD_W'(dym_s1) * PROD_W'(depth_s1);
			ny_s2    <= dyn_s1;
			depth_s2 <= depth_s1;
			rgb_s2   <= rgb_s1;
		end
	end

	// scale by 16 and add half the focal length for round to nearest
	always_comb begin
		push_data.num_x = {1'b0, px_s2, 4'b0000}
			+ NUM_W'(cfg.focal[HALF_W-1:1]);
		push_data.neg_x = nx_s2;
		push_data.num_y = {1'b0, py_s2, 4'b0000}
			+ NUM_W'(cfg.focal[2*HALF_W-1:HALF_W+1]);
		push_data.neg_y = ny_s2;
		push_data.depth = depth_s2;
		push_data.rgb   = rgb_s2;
	end

endmodule

// ===== sv/dpbu_queue.sv =====
// short queue of kept pixels between front and back
// uses dpbu_pkg and the assertion macros header
`include "depth_pixel_backprojection_unit_defines.svh"

module dpbu_queue
	import dpbu_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t push_data,
	input  logic  pop,
	output qent_t head,
	output logic  full,
	output logic  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	qent_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wptr_q;
	logic [PTR_W-1:0]  rptr_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	`DPBU_ASSERT_NOW(a_push_not_full, push, !full, "push into a full queue")
	`DPBU_ASSERT_NOW(a_pop_not_empty, pop, !empty, "pop from an empty queue")
	`DPBU_ASSERT_NEXT(a_fill_count, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "fill count slip")
	`DPBU_ASSERT_NEXT(a_drain_count, pop && !push, cnt_q == $past(cnt_q) - 1'b1, "drain count slip")

endmodule

// ===== sv/dpbu_div.sv =====
// pipelined restoring divider, DIV_BITS quotient bits per stage
// divisor is a static register value; uses dpbu_pkg
module dpbu_div
	import dpbu_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [NUM_W-1:0]  num,
	input  logic [HALF_W-1:0] den,
	output logic [DIV_W-1:0]  quo
);

	logic [HALF_W-1:0] rem_s [DIV_STAGES];
	logic [DIV_W-1:0]  quo_s [DIV_STAGES];
	logic [HALF_W-1:0] rem_d [DIV_STAGES];
	logic [DIV_W-1:0]  quo_d [DIV_STAGES];

	// quotient bits shift in at the bottom as dividend bits leave the top
	always_comb begin : div_steps
		logic [HALF_W-1:0] r;
		logic [DIV_W-1:0]  q;
		logic [HALF_W:0]   trial;
		for (int s = 0; s < DIV_STAGES; s++) begin
			r = (s == 0) ? '0 : rem_s[(s == 0) ? 0 : s - 1];
			q = (s == 0) ? DIV_W'(num) : quo_s[(s == 0) ? 0 : s - 1];
			for (int b = 0; b < DIV_BITS; b++) begin
				trial = {r, q[DIV_W-1]};
				q     = {q[DIV_W-2:0], 1'b0};
				if (trial >= {1'b0, den}) begin
					trial = trial - {1'b0, den};
					q[0]  = 1'b1;
				end
				r = trial[HALF_W-1:0];
			end
			rem_d[s] = r;
			quo_d[s] = q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s <= rem_d;
			quo_s <= quo_d;
		end
	end

	assign quo = quo_s[DIV_STAGES-1];

endmodule

// ===== sv/dpbu_back.sv =====
// back end: divides for camera x/y, applies the pose, rounds, saturates
// and holds the output beat; uses dpbu_pkg and dpbu_div
module dpbu_back
	import dpbu_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  qent_t                     head,
	input  logic                      q_empty,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [WORLD_W-1:0] world_x,
	output logic signed [WORLD_W-1:0] world_y,
	output logic signed [WORLD_W-1:0] world_z,
	output logic [COLOR_W-1:0]        point_red,
	output logic [COLOR_W-1:0]        point_green,
	output logic [COLOR_W-1:0]        point_blue
);

	localparam int ZC_W       = DEPTH_W + 5;
	localparam int XL_W       = COORD_W / 2;
	localparam int XH_W       = COORD_W - XL_W;
	localparam int PXH_W      = HALF_W + XH_W;
	localparam int PXL_W      = HALF_W + XL_W + 1;
	localparam int PZ_W       = HALF_W + ZC_W;
	localparam int HI_W       = PXH_W + 1;
	localparam int LO_W       = PZ_W + 2;
	localparam int ACC_W      = HI_W + XL_W + 1;
	localparam int RND_SHIFT  = 18;
	localparam int RND_W      = ACC_W - RND_SHIFT;
	localparam int WSUM_W     = RND_W + 1;
	localparam logic signed [ACC_W-1:0]  HALF_UP = ACC_W'(2**(RND_SHIFT-1));
	localparam logic signed [ACC_W-1:0]  HALF_DN = ACC_W'(2**(RND_SHIFT-1) - 1);
	localparam logic signed [WSUM_W-1:0] SAT_HI  = WSUM_W'(WORLD_MAX);
	localparam logic signed [WSUM_W-1:0] SAT_LO  = WSUM_W'(WORLD_MIN);

	typedef struct packed {
		logic               neg_x;
		logic               neg_y;
		logic [DEPTH_W-1:0] depth;
		rgb_t               rgb;
	} side_t;

	logic                      adv;
	logic [DIV_W-1:0]          quo_x;
	logic [DIV_W-1:0]          quo_y;
	logic [DIV_STAGES-1:0]     div_v_s;
	side_t                     div_pay_s [DIV_STAGES];
	side_t                     tail;

	logic signed [COORD_W-1:0] mag_x;
	logic signed [COORD_W-1:0] mag_y;
	logic signed [COORD_W-1:0] xc_d;
	logic signed [COORD_W-1:0] yc_d;

	logic                      v_s1, v_s2, v_s3, v_s4, v_s5;
	rgb_t                      rgb_s1, rgb_s2, rgb_s3, rgb_s4, rgb_s5;
	logic signed [COORD_W-1:0] xc_s1;
	logic signed [COORD_W-1:0] yc_s1;
	logic signed [ZC_W-1:0]    zc_s1;

	logic signed [PXH_W-1:0]   pxh_s2 [3];
	logic signed [PXL_W-1:0]   pxl_s2 [3];
	logic signed [PXH_W-1:0]   pyh_s2 [3];
	logic signed [PXL_W-1:0]   pyl_s2 [3];
	logic signed [PZ_W-1:0]    pz_s2  [3];
	logic signed [PXH_W-1:0]   pxh_d  [3];
	logic signed [PXL_W-1:0]   pxl_d  [3];
	logic signed [PXH_W-1:0]   pyh_d  [3];
	logic signed [PXL_W-1:0]   pyl_d  [3];
	logic signed [PZ_W-1:0]    pz_d   [3];

	logic signed [HI_W-1:0]    hi_s3  [3];
	logic signed [LO_W-1:0]    lo_s3  [3];
	logic signed [ACC_W-1:0]   acc_s4 [3];
	logic signed [RND_W-1:0]   rnd_s5 [3];
	logic signed [RND_W-1:0]   rnd_d  [3];
	logic signed [WORLD_W-1:0] world_d [3];
	logic signed [WORLD_W-1:0] world_q [3];
	rgb_t                      rgb_q;
	logic                      out_valid_q;

	// whole back end moves together unless an output beat is held
	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && !q_empty;

	dpbu_div u_div_x (
		.clk (clk),
		.en  (adv),
		.num (head.num_x),
		.den (cfg.focal[HALF_W-1:0]),
		.quo (quo_x)
	);

	dpbu_div u_div_y (
		.clk (clk),
		.en  (adv),
		.num (head.num_y),
		.den (cfg.focal[2*HALF_W-1:HALF_W]),
		.quo (quo_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v_s     <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			div_v_s     <= {div_v_s[DIV_STAGES-2:0], !q_empty};
			v_s1        <= div_v_s[DIV_STAGES-1];
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	// sidecar follows the divider stages
	always_ff @(posedge clk) begin
		if (adv) begin
			div_pay_s[0] <= '{neg_x: head.neg_x, neg_y: head.neg_y,
				depth: head.depth, rgb: head.rgb};
			for (int i = 1; i < DIV_STAGES; i++) begin
				div_pay_s[i] <= div_pay_s[i-1];
			end
		end
	end

	assign tail = div_pay_s[DIV_STAGES-1];

	// signed camera coordinates, zero focal length gives zero
	always_comb begin
		mag_x = $signed(quo_x);
		mag_y = $signed(quo_y);
		if (cfg.focal[HALF_W-1:0] == '0) begin
			xc_d = '0;
		end else begin
			xc_d = tail.neg_x ? -mag_x : mag_x;
		end
		if (cfg.focal[2*HALF_W-1:HALF_W] == '0) begin
			yc_d = '0;
		end else begin
			yc_d = tail.neg_y ? -mag_y : mag_y;
		end
	end

	// partial products: camera x and y split in two halves each
	always_comb begin : prods
		logic signed [HALF_W-1:0] r0, r1, r2;
		logic signed [XH_W-1:0]   xh, yh;
		logic signed [XL_W:0]     xl, yl;
		xh = $signed(xc_s1[COORD_W-1:XL_W]);
		yh = $signed(yc_s1[COORD_W-1:XL_W]);
		xl = $signed({1'b0, xc_s1[XL_W-1:0]});
		yl = $signed({1'b0, yc_s1[XL_W-1:0]});
		for (int k = 0; k < 3; k++) begin
			r0 = $signed(cfg.pose[k][HALF_W-1:0]);
			r1 = $signed(cfg.pose[k][2*HALF_W-1:HALF_W]);
			r2 = $signed(cfg.pose[k][3*HALF_W-1:2*HALF_W]);
			pxh_d[k] = PXH_W'(r0) * PXH_W'(xh);
			pxl_d[k] = PXL_W'(r0) * PXL_W'(xl);
			pyh_d[k] = PXH_W'(r1) * PXH_W'(yh);
			pyl_d[k] = PXL_W'(r1) * PXL_W'(yl);
			pz_d[k]  = PZ_W'(r2) * PZ_W'(zc_s1);
		end
	end

	// round to nearest, halves away from zero
	always_comb begin : rounding
		logic signed [ACC_W-1:0] biased;
		for (int k = 0; k < 3; k++) begin
			biased   = acc_s4[k] + (acc_s4[k][ACC_W-1] ? HALF_DN : HALF_UP);
			rnd_d[k] = $signed(biased[ACC_W-1:RND_SHIFT]);
		end
	end

	// add offset and clamp to the output range
	always_comb begin : offset_sat
		logic signed [WSUM_W-1:0] wsum;
		for (int k = 0; k < 3; k++) begin
			wsum = WSUM_W'(rnd_s5[k])
				+ WSUM_W'($signed(cfg.pose[k][4*HALF_W-1:3*HALF_W]));
			if (wsum > SAT_HI) begin
				world_d[k] = SAT_HI[WORLD_W-1:0];
			end else if (wsum < SAT_LO) begin
				world_d[k] = SAT_LO[WORLD_W-1:0];
			end else begin
				world_d[k] = wsum[WORLD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xc_s1  <= xc_d;
			yc_s1  <= yc_d;
			zc_s1  <= $signed({1'b0, tail.depth, 4'b0000});
			rgb_s1 <= tail.rgb;

			pxh_s2 <= pxh_d;
			pxl_s2 <= pxl_d;
			pyh_s2 <= pyh_d;
			pyl_s2 <= pyl_d;
			pz_s2  <= pz_d;
			rgb_s2 <= rgb_s1;

			for (int k = 0; k < 3; k++) begin
				hi_s3[k]  <= HI_W'(pxh_s2[k]) + HI_W'(pyh_s2[k]);
				lo_s3[k]  <= LO_W'(pxl_s2[k]) + LO_W'(pyl_s2[k]) + LO_W'(pz_s2[k]);
				acc_s4[k] <= (ACC_W'(hi_s3[k]) <<< XL_W) + ACC_W'(lo_s3[k]);
			end
			rgb_s3 <= rgb_s2;
			rgb_s4 <= rgb_s3;

			rnd_s5  <= rnd_d;
			rgb_s5  <= rgb_s4;

			world_q <= world_d;
			rgb_q   <= rgb_s5;
		end
	end

	assign out_valid   = out_valid_q;
	assign world_x     = world_q[0];
	assign world_y     = world_q[1];
	assign world_z     = world_q[2];
	assign point_red   = rgb_q.red;
	assign point_green = rgb_q.green;
	assign point_blue  = rgb_q.blue;

endmodule

// ===== sv/depth_pixel_backprojection_unit.sv =====
// top level of the depth pixel back-projection unit: config registers,
// front end, queue and back end; uses dpbu_pkg, dpbu_front, dpbu_queue, dpbu_back
//
//  channel | direction | handshake              | beat
//  --------+-----------+------------------------+-----------------------------------------
//  pixel   | in        | in_valid / in_stall    | pixel_row, pixel_col, depth_mm, in_red/green/blue
//  point   | out       | out_valid / out_stall  | world_x/y/z, point_red/green/blue
//  config  | in        | cfg_wen                | cfg_index, cfg_wdata
//
// one pixel beat accepted per clock while in_stall is low; dropped pixels leave no bubble
// a pixel beat reaches the point port through the front registers, the queue, the
// two 19-stage pipelined dividers (two quotient bits per stage, one per axis) and the back end registers
// reset clears all valid flags and queue pointers and loads default config
// in_stall rises only when the queue is full and a kept pixel waits to enter it
// a held output beat freezes the whole back end; the front keeps filling the queue
module depth_pixel_backprojection_unit
	import dpbu_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [ROW_W-1:0]             pixel_row,
	input  logic [COL_W-1:0]             pixel_col,
	input  logic [DEPTH_W-1:0]           depth_mm,
	input  logic [COLOR_W-1:0]           in_red,
	input  logic [COLOR_W-1:0]           in_green,
	input  logic [COLOR_W-1:0]           in_blue,

	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [WORLD_W-1:0]    world_x,
	output logic signed [WORLD_W-1:0]    world_y,
	output logic signed [WORLD_W-1:0]    world_z,
	output logic [COLOR_W-1:0]           point_red,
	output logic [COLOR_W-1:0]           point_green,
	output logic [COLOR_W-1:0]           point_blue,

	input  logic                         cfg_wen,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

	cfg_t  cfg_q;
	logic  push;
	qent_t push_data;
	logic  pop;
	qent_t head;
	logic  q_full;
	logic  q_empty;

	// config registers, unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_MIN_DEPTH: cfg_q.min_depth <= cfg_wdata[DEPTH_W-1:0];
				REG_MAX_DEPTH: cfg_q.max_depth <= cfg_wdata[DEPTH_W-1:0];
				REG_FOCAL:     cfg_q.focal     <= cfg_wdata[2*HALF_W-1:0];
				REG_CENTER:    cfg_q.center    <= cfg_wdata[2*HALF_W-1:0];
				REG_POSE_X:    cfg_q.pose[0]   <= cfg_wdata;
				REG_POSE_Y:    cfg_q.pose[1]   <= cfg_wdata;
				REG_POSE_Z:    cfg_q.pose[2]   <= cfg_wdata;
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	// front: grid, image and depth test, numerators for the dividers
	dpbu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel_row (pixel_row),
		.pixel_col (pixel_col),
		.depth_mm  (depth_mm),
		.in_red    (in_red),
		.in_green  (in_green),
		.in_blue   (in_blue),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	// queue of kept pixels, lets front and back stall apart
	dpbu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	// back: divide, rotate and translate, round, saturate, output register
	dpbu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head        (head),
		.q_empty     (q_empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.world_x     (world_x),
		.world_y     (world_y),
		.world_z     (world_z),
		.point_red   (point_red),
		.point_green (point_green),
		.point_blue  (point_blue)
	);

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench of depth_pixel_backprojection_unit: directed and random pixel beats,
// world points predicted in-bench from the register settings and checked in arrival order
// depends on dpbu_pkg and the unit under test only
module tb_top;
	import dpbu_pkg::*;

	localparam int     HALF_PERIOD    = 5;
	localparam int     DRAIN_CYCLES   = 64;       // leave room for the pipeline to drain
	localparam int     KEPT_PER_PHASE = 255;      // kept pixels per random phase
	localparam longint ROT_SCALE      = 262144;   // Q2.14 term times 1/16 mm coordinate
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;   // no register behind this index

	// one pixel beat as sent
	typedef struct packed {
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col;
		logic [DEPTH_W-1:0] depth;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} pixel_beat_t;

	// one world point beat as predicted
	typedef struct packed {
		logic signed [WORLD_W-1:0] x;
		logic signed [WORLD_W-1:0] y;
		logic signed [WORLD_W-1:0] z;
		logic [COLOR_W-1:0]        red;
		logic [COLOR_W-1:0]        green;
		logic [COLOR_W-1:0]        blue;
	} point_beat_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [ROW_W-1:0]     pixel_row = '0;
	logic [COL_W-1:0]     pixel_col = '0;
	logic [DEPTH_W-1:0]   depth_mm  = '0;
	logic [COLOR_W-1:0]   in_red    = '0;
	logic [COLOR_W-1:0]   in_green  = '0;
	logic [COLOR_W-1:0]   in_blue   = '0;

	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [WORLD_W-1:0] world_x;
	logic signed [WORLD_W-1:0] world_y;
	logic signed [WORLD_W-1:0] world_z;
	logic [COLOR_W-1:0]        point_red;
	logic [COLOR_W-1:0]        point_green;
	logic [COLOR_W-1:0]        point_blue;

	logic                  cfg_wen   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// bench copy of the register file, loaded with the documented reset values
	logic [DEPTH_W-1:0]    cfg_min    = 16'd10;
	logic [DEPTH_W-1:0]    cfg_max    = 16'd10000;
	logic [2*HALF_W-1:0]   cfg_focal  = 32'd550511640;
	logic [2*HALF_W-1:0]   cfg_center = 32'd251139064;
	logic [CFG_DATA_W-1:0] cfg_pose [3] = '{64'h0000_0000_0000_4000,
		64'h0000_0000_4000_0000, 64'h0000_4000_0000_0000};

	pixel_beat_t pixels_to_send [$];   // beats waiting for the driver
	point_beat_t points_due [$];       // predicted points, oldest first
	pixel_beat_t on_wire;              // beat currently presented on the pixel port
	int          beats_unaccepted = 0; // queued or presented, not yet taken by the unit
	int          bad_beats = 0;
	int          in_gap = 0;
	int          out_wait = 0;
	bit          in_calm = 1'b0;
	bit          out_calm = 1'b0;

	depth_pixel_backprojection_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_row   (pixel_row),
		.pixel_col   (pixel_col),
		.depth_mm    (depth_mm),
		.in_red      (in_red),
		.in_green    (in_green),
		.in_blue     (in_blue),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.world_x     (world_x),
		.world_y     (world_y),
		.world_z     (world_z),
		.point_red   (point_red),
		.point_green (point_green),
		.point_blue  (point_blue),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	always #HALF_PERIOD clk = ~clk;

	// round to nearest, halves away from zero; den is positive
	function automatic longint round_div(input longint num, input longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	// camera-space x or y in 1/16 mm; a zero focal length pins the axis to zero
	function automatic longint lift_axis(input longint pix, input longint centre,
			input longint focal, input longint depth);
		if (focal == 0)
			return 0;
		return round_div((pix * 16 - centre) * depth * 16, focal);
	endfunction

	// one row of the pose applied to the camera point, then clamped to 20 bits
	function automatic logic signed [WORLD_W-1:0] to_world(input logic [CFG_DATA_W-1:0] pose,
			input longint xc, input longint yc, input longint zc);
		longint acc;
		longint w;
		acc = longint'($signed(pose[15:0])) * xc + longint'($signed(pose[31:16])) * yc
			+ longint'($signed(pose[47:32])) * zc;
		w = round_div(acc, ROT_SCALE) + longint'($signed(pose[63:48]));
		if (w > WORLD_MAX)
			w = WORLD_MAX;
		if (w < WORLD_MIN)
			w = WORLD_MIN;
		return w[WORLD_W-1:0];
	endfunction

	// back-projects one pixel under the current settings; 0 when the pixel is dropped
	function automatic bit project_pixel(input pixel_beat_t p, output point_beat_t pt);
		longint xc;
		longint yc;
		longint zc;
		pt = '0;
		if (p.row >= IMAGE_HEIGHT || p.col >= IMAGE_WIDTH)
			return 1'b0;
		if (p.row % SUBSAMPLE_STEP != 0 || p.col % SUBSAMPLE_STEP != 0)
			return 1'b0;
		if (p.depth < cfg_min || p.depth > cfg_max)
			return 1'b0;
		xc = lift_axis(p.col, cfg_center[15:0], cfg_focal[15:0], p.depth);
		yc = lift_axis(p.row, cfg_center[31:16], cfg_focal[31:16], p.depth);
		zc = longint'(p.depth) * 16;
		pt.x = to_world(cfg_pose[0], xc, yc, zc);
		pt.y = to_world(cfg_pose[1], xc, yc, zc);
		pt.z = to_world(cfg_pose[2], xc, yc, zc);
		pt.red = p.red;
		pt.green = p.green;
		pt.blue = p.blue;
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			bad_beats++;
		end
	endtask

	// one register write, mirrored into the bench copy with the register's width
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_MIN_DEPTH: cfg_min = value[DEPTH_W-1:0];
			REG_MAX_DEPTH: cfg_max = value[DEPTH_W-1:0];
			REG_FOCAL:     cfg_focal = value[2*HALF_W-1:0];
			REG_CENTER:    cfg_center = value[2*HALF_W-1:0];
			REG_POSE_X:    cfg_pose[0] = value;
			REG_POSE_Y:    cfg_pose[1] = value;
			REG_POSE_Z:    cfg_pose[2] = value;
			default: ;
		endcase
	endtask

	task automatic send_pixel(input pixel_beat_t p);
		pixels_to_send = {pixels_to_send, p};
		beats_unaccepted++;
	endtask

	// wait for every beat taken and every point back, then for the pipeline to empty
	task automatic settle();
		while (beats_unaccepted != 0 || points_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// mostly on-grid pixels with in-window depth, a quarter raw noise
	task automatic queue_random(input int kept_goal);
		pixel_beat_t p;
		point_beat_t pt;
		int kept;
		kept = 0;
		while (kept < kept_goal) begin
			p.red = COLOR_W'($urandom);
			p.green = COLOR_W'($urandom);
			p.blue = COLOR_W'($urandom);
			if ($urandom_range(0, 3) == 0) begin
				p.row = ROW_W'($urandom);
				p.col = COL_W'($urandom);
				p.depth = DEPTH_W'($urandom);
			end else begin
				p.row = ROW_W'(SUBSAMPLE_STEP
					* $urandom_range(0, (IMAGE_HEIGHT - 1) / SUBSAMPLE_STEP));
				p.col = COL_W'(SUBSAMPLE_STEP
					* $urandom_range(0, (IMAGE_WIDTH - 1) / SUBSAMPLE_STEP));
				case ($urandom_range(0, 7))
					0: p.depth = cfg_min;
					1: p.depth = cfg_max;
					default: p.depth = DEPTH_W'($urandom_range(cfg_min, cfg_max));
				endcase
			end
			if (project_pixel(p, pt))
				kept++;
			send_pixel(p);
		end
	endtask

	// fresh settings for one random phase; narrow registers get junk in the unused bits
	task automatic pick_random_cfg(input int phase);
		logic [DEPTH_W-1:0]    lo;
		logic [DEPTH_W-1:0]    hi;
		logic [HALF_W-1:0]     fx;
		logic [HALF_W-1:0]     fy;
		logic [CFG_DATA_W-1:0] junk;
		junk = {$urandom, $urandom};
		lo = DEPTH_W'($urandom);
		hi = DEPTH_W'($urandom_range(lo, 16'hFFFF));
		if (phase == 0) begin
			lo = '0;
			hi = '1;
		end
		if (phase == 1)
			hi = (lo > 16'hFF00) ? 16'hFFFF : lo + DEPTH_W'($urandom_range(0, 255));
		fx = HALF_W'($urandom);
		fy = HALF_W'($urandom);
		if (phase == 2) begin
			// tiny focal lengths throw most points into saturation
			fx = HALF_W'($urandom_range(1, 64));
			fy = HALF_W'($urandom_range(1, 64));
		end
		if ($urandom_range(0, 7) == 0)
			fx = '0;
		if ($urandom_range(0, 7) == 0)
			fy = '0;
		write_reg(REG_MIN_DEPTH, {junk[63:16], lo});
		write_reg(REG_MAX_DEPTH, {junk[63:16], hi});
		write_reg(REG_FOCAL, {junk[63:32], fy, fx});
		write_reg(REG_CENTER, {junk[63:32], HALF_W'($urandom), HALF_W'($urandom)});
		write_reg(REG_POSE_X, {$urandom, $urandom});
		write_reg(REG_POSE_Y, {$urandom, $urandom});
		write_reg(REG_POSE_Z, {$urandom, $urandom});
	endtask

	// pixel driver: holds a stalled beat, predicts on acceptance, at times idles between beats
	always @(posedge clk) begin : drive_pixels
		point_beat_t pt;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				beats_unaccepted--;
				if (project_pixel(on_wire, pt))
					points_due = {points_due, pt};
			end
			// a stalled beat stays on the port untouched
			if (!(in_valid && in_stall)) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pixels_to_send.size() > 0) begin
					on_wire = pixels_to_send.pop_front();
					pixel_row <= on_wire.row;
					pixel_col <= on_wire.col;
					depth_mm <= on_wire.depth;
					in_red <= on_wire.red;
					in_green <= on_wire.green;
					in_blue <= on_wire.blue;
					in_valid <= 1'b1;
					// now and then switch between back-to-back beats and gapped beats
					if ($urandom_range(0, 49) == 0)
						in_calm = !in_calm;
					in_gap = in_calm ? 0 : $urandom_range(0, 10);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// point monitor: compares each taken point beat with the oldest prediction
	always @(posedge clk) begin : watch_points
		point_beat_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (points_due.size() == 0) begin
					$display("%0t unexpected point: expected none, actual x %0d y %0d z %0d",
						$time, world_x, world_y, world_z);
					bad_beats++;
				end else begin
					want = points_due.pop_front();
					check_field("world_x", $signed(want.x), world_x);
					check_field("world_y", $signed(want.y), world_y);
					check_field("world_z", $signed(want.z), world_z);
					check_field("point_red", want.red, point_red);
					check_field("point_green", want.green, point_green);
					check_field("point_blue", want.blue, point_blue);
				end
				if ($urandom_range(0, 49) == 0)
					out_calm = !out_calm;
				out_wait = out_calm ? 0 : $urandom_range(0, 10);
			end
			// stall count runs down only while a point is offered
			if (out_wait > 0) begin
				out_stall <= 1'b1;
				if (out_valid)
					out_wait--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: window edges, image edges, grid misses
		send_pixel('{9'd0, 10'd0, 16'd10, 8'd0, 8'd0, 8'd0});
		send_pixel('{9'd0, 10'd0, 16'd9, 8'd255, 8'd255, 8'd255});
		send_pixel('{9'd477, 10'd639, 16'd10000, 8'd255, 8'd0, 8'd128});
		send_pixel('{9'd477, 10'd639, 16'd10001, 8'd1, 8'd2, 8'd3});
		send_pixel('{9'd479, 10'd639, 16'd500, 8'd4, 8'd5, 8'd6});
		send_pixel('{9'd480, 10'd0, 16'd500, 8'd7, 8'd8, 8'd9});
		send_pixel('{9'd511, 10'd1023, 16'd65535, 8'd255, 8'd255, 8'd255});
		send_pixel('{9'd0, 10'd640, 16'd500, 8'd10, 8'd11, 8'd12});
		send_pixel('{9'd3, 10'd1, 16'd500, 8'd13, 8'd14, 8'd15});
		send_pixel('{9'd240, 10'd318, 16'd1000, 8'd170, 8'd85, 8'd51});
		send_pixel('{9'd0, 10'd0, 16'd0, 8'd16, 8'd17, 8'd18});
		send_pixel('{9'd99, 10'd300, 16'd65535, 8'd19, 8'd20, 8'd21});
		settle();

		// full window, tiny focal lengths, extreme pose terms: saturation both ways
		write_reg(REG_MIN_DEPTH, 64'h0);
		write_reg(REG_MAX_DEPTH, 64'hFFFF);
		write_reg(REG_FOCAL, 64'h0001_0001);
		write_reg(REG_CENTER, 64'h0);
		write_reg(REG_POSE_X, 64'h7FFF_7FFF_7FFF_7FFF);
		write_reg(REG_POSE_Y, 64'h8000_8000_8000_8000);
		write_reg(REG_POSE_Z, 64'h8000_0000_0000_0000);
		send_pixel('{9'd0, 10'd0, 16'd0, 8'd0, 8'd255, 8'd0});
		send_pixel('{9'd0, 10'd0, 16'd65535, 8'd255, 8'd0, 8'd255});
		send_pixel('{9'd477, 10'd639, 16'd65535, 8'd128, 8'd64, 8'd32});
		send_pixel('{9'd3, 10'd3, 16'd1, 8'd22, 8'd23, 8'd24});
		send_pixel('{9'd0, 10'd639, 16'd1, 8'd25, 8'd26, 8'd27});
		settle();

		// zero focal x, centre at its top, and a write to an index with no register
		write_reg(REG_FOCAL, 64'h0010_0000);
		write_reg(REG_CENTER, 64'hFFFF_FFFF);
		write_reg(REG_POSE_X, 64'h0000_C000_4000_4000);
		write_reg(REG_POSE_Y, 64'h7FFF_0000_C000_4000);
		write_reg(REG_POSE_Z, 64'h0123_4000_0000_0000);
		write_reg(REG_NONE, '1);
		send_pixel('{9'd0, 10'd0, 16'd1234, 8'd28, 8'd29, 8'd30});
		send_pixel('{9'd477, 10'd639, 16'd65535, 8'd31, 8'd32, 8'd33});
		send_pixel('{9'd240, 10'd321, 16'd3000, 8'd34, 8'd35, 8'd36});
		settle();

		// inverted bounds: nothing gets through
		write_reg(REG_MIN_DEPTH, 64'd1000);
		write_reg(REG_MAX_DEPTH, 64'd999);
		send_pixel('{9'd0, 10'd0, 16'd999, 8'd37, 8'd38, 8'd39});
		send_pixel('{9'd0, 10'd0, 16'd1000, 8'd40, 8'd41, 8'd42});
		send_pixel('{9'd3, 10'd3, 16'd500, 8'd43, 8'd44, 8'd45});
		send_pixel('{9'd6, 10'd6, 16'd65535, 8'd46, 8'd47, 8'd48});
		settle();

		// random phases, each under its own settings
		for (int phase = 0; phase < 5; phase++) begin
			pick_random_cfg(phase);
			queue_random(KEPT_PER_PHASE);
			settle();
		end

		if (bad_beats == 0 && points_due.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin : watchdog
		#5000000;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== depth_pixel_backprojection_unit.f =====
+incdir+sv
sv/dpbu_pkg.sv
sv/dpbu_front.sv
sv/dpbu_queue.sv
sv/dpbu_div.sv
sv/dpbu_back.sv
sv/depth_pixel_backprojection_unit.sv
test/tb_top.sv
